// ----- hw/rtl/lidar_point_curvature_classifier_top_defines.svh -----
// Assertion helpers used by the checker file of the curvature classifier.
`ifndef LIDAR_POINT_CURVATURE_CLASSIFIER_TOP_DEFINES_SVH
`define LIDAR_POINT_CURVATURE_CLASSIFIER_TOP_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is high.
`define LPCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define LPCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lpcc_pkg.sv -----
`timescale 1ns / 1ps

package lpcc_pkg;

   localparam int COORD_W     = 19;
   localparam int INDEX_W     = 17;
   localparam int CURV_W      = 47;
   localparam int GAP_W       = 40;
   // neighbor gap per axis and its square
   localparam int GAP_DIFF_W  = COORD_W + 1;
   localparam int GAP_SQ_W    = 2 * COORD_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = CURV_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_CURV_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_THRESHOLD  = 2'd1;

   localparam logic [CURV_W-1:0] CURV_MAX              = {CURV_W{1'b1}};
   localparam logic [CURV_W-1:0] CURV_THRESHOLD_RESET  = 47'd100000;
   localparam logic [GAP_W-1:0]  GAP_THRESHOLD_RESET   = 40'd50000;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

// ----- hw/rtl/lidar_point_curvature_classifier_top.sv -----
// Path: the input word that completes its window passes stages 0 to 3 to its result word.
// Throughput: one input word per cycle unless rsp_ready stalls; 2*HALF_WINDOW+1 words
//   fill a frame's window before its first result, then each input word yields a result word.
// Reset: synchronous, active high; clears window fill, frame count, running sums, pipeline
//   valids and restores both thresholds. No clearing pass is needed.
`timescale 1ns / 1ps

module lidar_point_curvature_classifier_top #(
   parameter int MAX_POINTS  = 131072,
   parameter int HALF_WINDOW = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // register write port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lpcc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lpcc_pkg::CSR_DATA_W-1:0]        csr_data,
   // point stream
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [lpcc_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [lpcc_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [lpcc_pkg::COORD_W-1:0]    req_point_z,
   input  logic                                   req_frame_start,
   // result stream
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [lpcc_pkg::INDEX_W-1:0]           rsp_centre_index,
   output logic signed [lpcc_pkg::COORD_W-1:0]    rsp_centre_x,
   output logic signed [lpcc_pkg::COORD_W-1:0]    rsp_centre_y,
   output logic signed [lpcc_pkg::COORD_W-1:0]    rsp_centre_z,
   output logic [lpcc_pkg::CURV_W-1:0]            rsp_curvature,
   output logic                                   rsp_corner_candidate,
   output logic                                   rsp_flat_candidate,
   output logic                                   rsp_close_to_previous,
   output logic                                   rsp_close_to_next
);

   // Pipeline:
   //   stage 0  point window (shift register) plus a running sum of the window per axis
   //   stage 1  window difference per axis = sum - WIN_LEN * centre, neighbor gaps
   //   stage 2  squares (one multiplier per axis and per gap axis)
   //   stage 3  output register: adds, saturation, threshold compares
   // Each stage loads when it is empty or its word moves on, so bubbles collapse; while a
   // finished result waits on rsp_ready, the point side flows only until the stages are full.

   localparam int WIN_LEN   = 2 * HALF_WINDOW + 1;
   localparam int FILL_W    = $clog2(WIN_LEN + 1);
   localparam int CNT_W     = $clog2(MAX_POINTS);
   localparam int IDX_CALC_W = (CNT_W > lpcc_pkg::INDEX_W) ? CNT_W : lpcc_pkg::INDEX_W;
   // running window sum: up to WIN_LEN coordinates
   localparam int SUM_W     = lpcc_pkg::COORD_W + $clog2(WIN_LEN);
   // window difference: magnitude up to 4*HALF_WINDOW*2^18
   localparam int DIFF_W    = lpcc_pkg::COORD_W + $clog2(4 * HALF_WINDOW + 1);
   localparam int MAG_W     = DIFF_W - 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int CSUM_W    = SQ_W + 2;
   localparam int CMP_W     = (CSUM_W > lpcc_pkg::CURV_W) ? CSUM_W : lpcc_pkg::CURV_W;

   localparam logic signed [DIFF_W-1:0] WIN_MUL = DIFF_W'(WIN_LEN);

   // ---------------------------------------------------------------- registers
   logic [lpcc_pkg::CURV_W-1:0] curv_thr_ff;
   logic [lpcc_pkg::GAP_W-1:0]  gap_thr_ff;

   // stage 0
   lpcc_pkg::coord_type         win_ff [WIN_LEN][3];
   logic signed [SUM_W-1:0]     sum_ff [3];
   logic signed [SUM_W-1:0]     sum_in [3];
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            newest;
   logic [IDX_CALC_W-1:0]       idx_wide;
   logic [lpcc_pkg::INDEX_W-1:0] idx0_ff, idx0_in;
   logic                        v0_ff, v0_in;
   lpcc_pkg::coord_type         pt [3];
   lpcc_pkg::coord_type         drop [3];
   logic                        req_accept;

   // stage 1
   logic                        v1_ff, v1_in;
   logic signed [DIFF_W-1:0]    d1_ff [3];
   logic signed [DIFF_W-1:0]    d1_in [3];
   logic signed [DIFF_W-1:0]    ctr_ext [3];
   logic signed [lpcc_pkg::GAP_DIFF_W-1:0] gp1_ff [3];
   logic signed [lpcc_pkg::GAP_DIFF_W-1:0] gp1_in [3];
   logic signed [lpcc_pkg::GAP_DIFF_W-1:0] gn1_ff [3];
   logic signed [lpcc_pkg::GAP_DIFF_W-1:0] gn1_in [3];
   lpcc_pkg::coord_type         c1_ff [3];
   logic [lpcc_pkg::INDEX_W-1:0] idx1_ff;

   // stage 2
   logic                        v2_ff, v2_in;
   logic signed [2*DIFF_W-1:0]  prod_c [3];
   logic signed [2*lpcc_pkg::GAP_DIFF_W-1:0] prod_p [3];
   logic signed [2*lpcc_pkg::GAP_DIFF_W-1:0] prod_n [3];
   logic [SQ_W-1:0]             sq2_ff [3];
   logic [lpcc_pkg::GAP_SQ_W-1:0] gsp2_ff [3];
   logic [lpcc_pkg::GAP_SQ_W-1:0] gsn2_ff [3];
   lpcc_pkg::coord_type         c2_ff [3];
   logic [lpcc_pkg::INDEX_W-1:0] idx2_ff;

   // stage 3 (output)
   logic                        v3_ff, v3_in;
   logic [CSUM_W-1:0]           csum;
   logic [CMP_W-1:0]            csum_cmp;
   logic [lpcc_pkg::CURV_W-1:0] curv_in;
   logic [lpcc_pkg::GAP_W-1:0]  gsum_p, gsum_n;
   logic [lpcc_pkg::INDEX_W-1:0] idx3_ff;
   lpcc_pkg::coord_type         c3_ff [3];
   logic [lpcc_pkg::CURV_W-1:0] curv3_ff;
   logic                        corner3_ff, flat3_ff, cp3_ff, cn3_ff;

   // stage readies
   logic                        rdy1, rdy2, rdy3;

   // ---------------------------------------------------------------- flow control
   always_comb begin
      rdy3      = !v3_ff || rsp_ready;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      req_ready = !v0_ff || rdy1;
      req_accept = req_valid && req_ready;
      v3_in     = rdy3 ? v2_ff : v3_ff;
      v2_in     = rdy2 ? v1_ff : v2_ff;
      v1_in     = rdy1 ? v0_ff : v1_ff;
   end

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- stage 0
   // The running sum adds the new point and drops the oldest one once the window
   // is full. A frame start restarts the sum at the new point, so the stale window
   // contents are never read.
   always_comb begin
      pt[0] = req_point_x;
      pt[1] = req_point_y;
      pt[2] = req_point_z;
      for (int k = 0; k < 3; k++) begin
         drop[k] = (!req_frame_start && fill_ff == FILL_W'(WIN_LEN)) ? win_ff[0][k] : '0;
         sum_in[k] = req_frame_start ? SUM_W'(pt[k])
                                     : sum_ff[k] + SUM_W'(pt[k]) - SUM_W'(drop[k]);
      end

      if (req_frame_start) begin
         fill_in = FILL_W'(1);
      end else if (fill_ff < FILL_W'(WIN_LEN)) begin
         fill_in = fill_ff + FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end

      // frame index saturates at MAX_POINTS-1
      newest = req_frame_start ? '0 : cnt_ff;
      cnt_in = (newest < CNT_W'(MAX_POINTS - 1)) ? newest + CNT_W'(1) : newest;

      // centre sits HALF_WINDOW words behind the newest point
      idx_wide = IDX_CALC_W'(newest) - IDX_CALC_W'(HALF_WINDOW);
      idx0_in  = idx_wide[lpcc_pkg::INDEX_W-1:0];

      v0_in = req_accept ? (fill_in == FILL_W'(WIN_LEN)) : (rdy1 ? 1'b0 : v0_ff);
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ctr_ext[k] = DIFF_W'(win_ff[HALF_WINDOW][k]);
         // neighbors minus 2*HALF_WINDOW * centre == window sum minus WIN_LEN * centre
         d1_in[k]   = DIFF_W'(sum_ff[k]) - ctr_ext[k] * WIN_MUL;
         gp1_in[k]  = lpcc_pkg::GAP_DIFF_W'(win_ff[HALF_WINDOW][k])
                    - lpcc_pkg::GAP_DIFF_W'(win_ff[HALF_WINDOW-1][k]);
         gn1_in[k]  = lpcc_pkg::GAP_DIFF_W'(win_ff[HALF_WINDOW][k])
                    - lpcc_pkg::GAP_DIFF_W'(win_ff[HALF_WINDOW+1][k]);
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_c[k] = d1_ff[k] * d1_ff[k];
         prod_p[k] = gp1_ff[k] * gp1_ff[k];
         prod_n[k] = gn1_ff[k] * gn1_ff[k];
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Curvature saturates at all ones; only wide windows can get there.
   always_comb begin
      csum     = CSUM_W'(sq2_ff[0]) + CSUM_W'(sq2_ff[1]) + CSUM_W'(sq2_ff[2]);
      csum_cmp = CMP_W'(csum);
      curv_in  = (csum_cmp > CMP_W'(lpcc_pkg::CURV_MAX)) ? lpcc_pkg::CURV_MAX
                                                          : csum_cmp[lpcc_pkg::CURV_W-1:0];
      gsum_p   = lpcc_pkg::GAP_W'(gsp2_ff[0]) + lpcc_pkg::GAP_W'(gsp2_ff[1])
               + lpcc_pkg::GAP_W'(gsp2_ff[2]);
      gsum_n   = lpcc_pkg::GAP_W'(gsn2_ff[0]) + lpcc_pkg::GAP_W'(gsn2_ff[1])
               + lpcc_pkg::GAP_W'(gsn2_ff[2]);
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         curv_thr_ff <= lpcc_pkg::CURV_THRESHOLD_RESET;
         gap_thr_ff  <= lpcc_pkg::GAP_THRESHOLD_RESET;
         fill_ff     <= '0;
         cnt_ff      <= '0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
         end
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lpcc_pkg::CSR_CURV_THRESHOLD: curv_thr_ff <= csr_data;
               lpcc_pkg::CSR_GAP_THRESHOLD:  gap_thr_ff  <= csr_data[lpcc_pkg::GAP_W-1:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            fill_ff <= fill_in;
            cnt_ff  <= cnt_in;
            for (int k = 0; k < 3; k++) begin
               sum_ff[k] <= sum_in[k];
            end
         end
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[i][k] <= win_ff[i+1][k];
            end
         end
         for (int k = 0; k < 3; k++) begin
            win_ff[WIN_LEN-1][k] <= pt[k];
         end
         idx0_ff <= idx0_in;
      end
      if (rdy1 && v0_ff) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k]  <= d1_in[k];
            gp1_ff[k] <= gp1_in[k];
            gn1_ff[k] <= gn1_in[k];
            c1_ff[k]  <= win_ff[HALF_WINDOW][k];
         end
         idx1_ff <= idx0_ff;
      end
      if (rdy2 && v1_ff) begin
         for (int k = 0; k < 3; k++) begin
            sq2_ff[k]  <= prod_c[k][SQ_W-1:0];
            gsp2_ff[k] <= prod_p[k][lpcc_pkg::GAP_SQ_W-1:0];
            gsn2_ff[k] <= prod_n[k][lpcc_pkg::GAP_SQ_W-1:0];
            c2_ff[k]   <= c1_ff[k];
         end
         idx2_ff <= idx1_ff;
      end
      if (rdy3 && v2_ff) begin
         for (int k = 0; k < 3; k++) begin
            c3_ff[k] <= c2_ff[k];
         end
         idx3_ff    <= idx2_ff;
         curv3_ff   <= curv_in;
         // equal to the threshold: neither corner nor flat
         corner3_ff <= curv_in > curv_thr_ff;
         flat3_ff   <= curv_in < curv_thr_ff;
         cp3_ff     <= gsum_p <= gap_thr_ff;
         cn3_ff     <= gsum_n <= gap_thr_ff;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid             = v3_ff;
   assign rsp_centre_index      = idx3_ff;
   assign rsp_centre_x          = c3_ff[0];
   assign rsp_centre_y          = c3_ff[1];
   assign rsp_centre_z          = c3_ff[2];
   assign rsp_curvature         = curv3_ff;
   assign rsp_corner_candidate  = corner3_ff;
   assign rsp_flat_candidate    = flat3_ff;
   assign rsp_close_to_previous = cp3_ff;
   assign rsp_close_to_next     = cn3_ff;

endmodule

// ----- hw/rtl/lpcc_checker.sv -----
`timescale 1ns / 1ps
`include "lidar_point_curvature_classifier_top_defines.svh"

module lpcc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [lpcc_pkg::COORD_W-1:0] req_point_x,
   input logic signed [lpcc_pkg::COORD_W-1:0] req_point_y,
   input logic signed [lpcc_pkg::COORD_W-1:0] req_point_z,
   input logic                                req_frame_start,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [lpcc_pkg::INDEX_W-1:0]        rsp_centre_index,
   input logic signed [lpcc_pkg::COORD_W-1:0] rsp_centre_x,
   input logic signed [lpcc_pkg::COORD_W-1:0] rsp_centre_y,
   input logic signed [lpcc_pkg::COORD_W-1:0] rsp_centre_z,
   input logic [lpcc_pkg::CURV_W-1:0]         rsp_curvature,
   input logic                                rsp_corner_candidate,
   input logic                                rsp_flat_candidate,
   input logic                                rsp_close_to_previous,
   input logic                                rsp_close_to_next
);

   // a waiting point word keeps valid and its contents
   property p_req_hold;
      req_valid && !req_ready |=> req_valid && $stable(req_point_x) && $stable(req_point_y)
         && $stable(req_point_z) && $stable(req_frame_start);
   endproperty

   // a stalled result word keeps valid and its contents
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_centre_index)
         && $stable(rsp_centre_x) && $stable(rsp_centre_y) && $stable(rsp_centre_z)
         && $stable(rsp_curvature) && $stable(rsp_corner_candidate)
         && $stable(rsp_flat_candidate) && $stable(rsp_close_to_previous)
         && $stable(rsp_close_to_next);
   endproperty

   // corner and flat exclude each other and a corner never has zero curvature
   property p_class;
      rsp_valid && rsp_corner_candidate |-> !rsp_flat_candidate && rsp_curvature != '0;
   endproperty

   // nothing is pending right after reset
   `LPCC_ASSERT_ALWAYS(a_reset_empties_output, clock, reset |=> !rsp_valid, "result valid after reset")

   `LPCC_ASSERT(a_req_hold, clock, reset, p_req_hold, "waiting point word changed")

   `LPCC_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result word changed")

   `LPCC_ASSERT(a_class_consistent, clock, reset, p_class, "inconsistent corner or flat flags")

endmodule

bind lidar_point_curvature_classifier_top lpcc_checker u_lpcc_checker (.*);
